FILE: sv/ttc_pkg.sv
// ----------------------------------------------------------------------------
// ttc_pkg: shared definitions of the tachometer trend classifier
// Field widths, the history depth, register indexes and trend codes that
// the block and its testbench use.
// ----------------------------------------------------------------------------
package ttc_pkg;

  // Payload field widths.
  localparam int PULSE_W = 4;
  localparam int RPM_W   = 16;
  localparam int TREND_W = 2;
  localparam int CFG_W   = 16;

  // Stream bus widths, rounded up to whole bytes, and the config address width.
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_ADDR_W  = 2;

  // Depth of the speed history line (1 to 16).
  localparam int HISTORY_DEPTH = 4;
  // Wide enough to hold HISTORY_DEPTH full-scale speeds.
  localparam int SUM_W = RPM_W + $clog2(HISTORY_DEPTH);

  // Serial datapath: 32-bit dividend, 16-bit divisor, step counter.
  localparam int NUM_W = 32;
  localparam int CNT_W = 6;

  // 60 s per minute over 1 ms per tick.
  localparam logic [NUM_W-1:0] RPM_SCALE = NUM_W'(60000);

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] WINDOW_RST = CFG_W'(1000);
  localparam logic [CFG_W-1:0] FLOOR_RST  = CFG_W'(0);
  localparam logic [CFG_W-1:0] LIMIT_RST  = CFG_W'(200);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WINDOW_MS   = 2'd0,
    CFG_RPM_FLOOR   = 2'd1,
    CFG_TREND_LIMIT = 2'd2
  } cfg_idx_t;

  typedef enum logic [TREND_W-1:0] {
    TREND_ZERO    = 2'd0,
    TREND_STABLE  = 2'd1,
    TREND_RISING  = 2'd2,
    TREND_FALLING = 2'd3
  } trend_t;

endpackage

FILE: sv/tachometer_trend_classifier.sv
// ----------------------------------------------------------------------------
// tachometer_trend_classifier: rpm measurement with trend classification
// Counts pulses per millisecond tick, computes rpm at the end of each window
// with a bit-serial multiply and divide, and grades it against the history.
// ----------------------------------------------------------------------------
// Each input beat is one millisecond tick carrying the rotation pulses seen
// in it. Ticks that do not close the window are absorbed while idle and
// produce no output. The tick whose elapsed count exceeds window_ms produces
// exactly one output beat with the rpm over the window (pulses * 60000 /
// ticks, truncated, saturated at 65535) and a trend code: zero when the rpm
// is at or below rpm_floor, rising or falling when the history mean differs
// from the new rpm by at least trend_limit, stable otherwise. The history
// holds the previous HISTORY_DEPTH results and is cleared by reset. Such a
// closing tick occupies the block while a shift-add multiplier works one
// pulse-count bit per cycle, then a single restoring divider produces one
// quotient bit per cycle, first the 32-bit quotient from which the rpm is
// taken, then the SUM_W-bit history mean, and a final step loads the output
// register. in_tready is low during that time; it returns high while the
// finished result may still wait in the output register, and a later result
// waits in that final step until the earlier one is taken, for as long as
// the receiver stalls.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata in any cycle;
// it should change only while the block is idle.
// ----------------------------------------------------------------------------
module tachometer_trend_classifier (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input tick stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ttc_pkg::IN_TDATA_W-1:0]   in_tdata,   // [3:0] pulses, rest zero
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ttc_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [15:0] speed_rpm,
                                                       // [17:16] trend, rest zero
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [ttc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [ttc_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int RPM_W = ttc_pkg::RPM_W;
  localparam int NUM_W = ttc_pkg::NUM_W;
  localparam int SUM_W = ttc_pkg::SUM_W;
  localparam int CNT_W = ttc_pkg::CNT_W;
  localparam int DEPTH = ttc_pkg::HISTORY_DEPTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_RPM,
    ST_DIV_MEAN,
    ST_FIN
  } state_t;

  // Configuration registers.
  logic [RPM_W-1:0] window_r, floor_r, limit_r;

  // Window counters and history.
  logic [RPM_W-1:0] pulse_total_r, elapsed_r;
  logic [RPM_W-1:0] last_speed_r;
  logic [RPM_W-1:0] hist_r [DEPTH];
  logic [SUM_W-1:0] hist_sum_r;

  // Serial datapath.
  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [RPM_W-1:0] mplr_r;    // pulse total, consumed MSB first
  logic [NUM_W-1:0] num_r;     // product, then dividend / quotient
  logic [RPM_W-1:0] rem_r;
  logic [RPM_W-1:0] den_r;
  logic [RPM_W-1:0] speed_r;
  logic [RPM_W-1:0] mean_r;

  // Output register.
  logic                      out_valid_r;
  logic [RPM_W-1:0]          out_speed_r;
  ttc_pkg::trend_t           out_trend_r;

  // Tick accounting.
  logic                   in_fire;
  logic [RPM_W:0]         pulse_sum;
  logic [RPM_W-1:0]       pulse_total_nxt, elapsed_nxt;
  logic                   window_done;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign pulse_sum       = {1'b0, pulse_total_r} + (RPM_W+1)'(in_tdata[ttc_pkg::PULSE_W-1:0]);
  assign pulse_total_nxt = pulse_sum[RPM_W] ? '1 : pulse_sum[RPM_W-1:0];
  assign elapsed_nxt     = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign window_done     = elapsed_nxt > window_r;

  // One shift-add step of the multiplier.
  logic [NUM_W-1:0] mul_nxt;
  assign mul_nxt = {num_r[NUM_W-2:0], 1'b0} + (mplr_r[RPM_W-1] ? ttc_pkg::RPM_SCALE : '0);

  // One restoring divide step: shift in a dividend bit, subtract if it fits.
  logic [RPM_W:0]   rem_shift;
  logic [RPM_W+1:0] trial;
  logic             q_bit;
  logic [RPM_W-1:0] rem_nxt;
  assign rem_shift = {rem_r, num_r[NUM_W-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, den_r};
  assign q_bit     = !trial[RPM_W+1];
  assign rem_nxt   = q_bit ? trial[RPM_W-1:0] : rem_shift[RPM_W-1:0];

  // Saturated rpm once the full 32-bit quotient sits in num_r.
  logic [RPM_W-1:0] speed_sat;
  assign speed_sat = (num_r[NUM_W-1:RPM_W] != '0) ? '1 : num_r[RPM_W-1:0];

  // Trend grading: rising when mean + limit <= speed, falling when
  // mean >= speed + limit (checked in that order).
  logic [RPM_W+1:0] mean_plus_lim, speed_plus_lim;
  ttc_pkg::trend_t  trend_nxt;
  assign mean_plus_lim  = {2'b00, mean_r} + {2'b00, limit_r};
  assign speed_plus_lim = {2'b00, speed_r} + {2'b00, limit_r};

  always_comb begin
    if (speed_r <= floor_r) begin
      trend_nxt = ttc_pkg::TREND_ZERO;
    end else if (mean_plus_lim <= {2'b00, speed_r}) begin
      trend_nxt = ttc_pkg::TREND_RISING;
    end else if ({2'b00, mean_r} >= speed_plus_lim) begin
      trend_nxt = ttc_pkg::TREND_FALLING;
    end else begin
      trend_nxt = ttc_pkg::TREND_STABLE;
    end
  end

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= ttc_pkg::WINDOW_RST;
      floor_r  <= ttc_pkg::FLOOR_RST;
      limit_r  <= ttc_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ttc_pkg::CFG_WINDOW_MS:   window_r <= cfg_wdata;
        ttc_pkg::CFG_RPM_FLOOR:   floor_r  <= cfg_wdata;
        ttc_pkg::CFG_TREND_LIMIT: limit_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Main sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pulse_total_r <= '0;
      elapsed_r     <= '0;
      last_speed_r  <= '0;
      hist_sum_r    <= '0;
      for (int k = 0; k < DEPTH; k++) begin
        hist_r[k] <= '0;
      end
      out_valid_r   <= 1'b0;
      cnt_r         <= '0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (window_done) begin
              // Retire the previous rpm into the history; the running sum
              // follows the shift.
              for (int k = DEPTH - 1; k > 0; k--) begin
                hist_r[k] <= hist_r[k-1];
              end
              hist_r[0]     <= last_speed_r;
              hist_sum_r    <= hist_sum_r - SUM_W'(hist_r[DEPTH-1]) + SUM_W'(last_speed_r);
              mplr_r        <= pulse_total_nxt;
              den_r         <= elapsed_nxt;
              num_r         <= '0;
              cnt_r         <= CNT_W'(RPM_W);
              pulse_total_r <= '0;
              elapsed_r     <= '0;
              state_r       <= ST_MUL;
            end else begin
              pulse_total_r <= pulse_total_nxt;
              elapsed_r     <= elapsed_nxt;
            end
          end
        end
        ST_MUL: begin
          num_r  <= mul_nxt;
          mplr_r <= {mplr_r[RPM_W-2:0], 1'b0};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            rem_r   <= '0;
            cnt_r   <= CNT_W'(NUM_W);
            state_r <= ST_DIV_RPM;
          end
        end
        ST_DIV_RPM: begin
          num_r <= {num_r[NUM_W-2:0], q_bit};
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            // Quotient complete: take the rpm and start the mean.
            speed_r      <= speed_sat;
            last_speed_r <= speed_sat;
            num_r        <= {hist_sum_r, {(NUM_W-SUM_W){1'b0}}};
            rem_r        <= '0;
            den_r        <= RPM_W'(DEPTH);
            cnt_r        <= CNT_W'(SUM_W);
            state_r      <= ST_DIV_MEAN;
          end
        end
        ST_DIV_MEAN: begin
          num_r <= {num_r[NUM_W-2:0], q_bit};
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            // The mean never exceeds a full-scale rpm.
            mean_r  <= num_r[RPM_W-1:0];
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_speed_r <= speed_r;
            out_trend_r <= trend_nxt;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ttc_pkg::OUT_TDATA_W-RPM_W-ttc_pkg::TREND_W){1'b0}},
                       out_trend_r, out_speed_r};

endmodule

FILE: sv/ttc_checker.sv
// ----------------------------------------------------------------------------
// ttc_checker: port-level checks of the tachometer trend classifier
// Watches the top-level ports only and is attached by the bind below.
// ----------------------------------------------------------------------------
module ttc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ttc_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // A stalled result beat holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // A zero rpm is never above the floor, so it always grades as zero.
  a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15:0] == '0 |-> out_tdata[17:16] == ttc_pkg::TREND_ZERO)
    else $error("zero rpm reported with a nonzero trend");

  // The input side only stops after taking a window-closing tick.
  a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid))
    else $error("input stalled without an accepted tick");

  // A new result appears only after a computation kept the input stalled.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a computation");

endmodule

bind tachometer_trend_classifier ttc_checker u_ttc_checker (.*);

FILE: bench/tachometer_trend_classifier_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tachometer_trend_classifier_tb: self-checking regression of the tachometer
// The bench streams millisecond ticks into the block and keeps its own
// bit-true tracker of the pulse and tick counters, the speed history and the
// trend grading. Every result beat is checked field by field against the
// oldest predicted reading. It runs one window at the reset settings, a
// directed part, then several random register settings with short windows.
// ----------------------------------------------------------------------------
module tachometer_trend_classifier_tb;

  localparam int RPM_W         = ttc_pkg::RPM_W;
  localparam int CFG_W         = ttc_pkg::CFG_W;
  localparam int PULSE_W       = ttc_pkg::PULSE_W;
  localparam int TREND_W       = ttc_pkg::TREND_W;
  localparam int IN_TDATA_W    = ttc_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W   = ttc_pkg::OUT_TDATA_W;
  localparam int CFG_ADDR_W    = ttc_pkg::CFG_ADDR_W;
  localparam int SUM_W         = ttc_pkg::SUM_W;
  localparam int HISTORY_DEPTH = ttc_pkg::HISTORY_DEPTH;

  // A closing tick keeps the block busy for the multiply and the two divides.
  localparam int CALC_CYCLES   = 16 + 33 + SUM_W + 2;
  // Hold-off after the last reading, before registers change or the run ends.
  localparam int SETTLE_CYCLES = CALC_CYCLES + 16;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int STALL_LIMIT   = 4000;
  // Percentage of cycles in which either side holds off.
  localparam int IDLE_PCT      = 26;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_TICKS   = 12;
  // Ticks of the reset-settings window from which neither side holds off.
  localparam int QUIET_FROM    = 854;
  localparam logic [CFG_W-1:0] REG_MAX    = CFG_W'(65535);

  // One predicted result beat.
  typedef struct packed {
    logic [RPM_W-1:0] speed;
    ttc_pkg::trend_t  trend;
  } reading_t;

  // Tracks the tachometer state and holds the readings still owed by the block.
  class rpm_ledger;
    logic [CFG_W-1:0] window_ms;
    logic [CFG_W-1:0] rpm_floor;
    logic [CFG_W-1:0] trend_limit;
    logic [RPM_W-1:0] pulse_total;
    logic [RPM_W-1:0] elapsed;
    logic [RPM_W-1:0] last_speed;
    logic [RPM_W-1:0] history [HISTORY_DEPTH];
    reading_t         readings [$];
    int               mismatches;

    function new();
      window_ms   = ttc_pkg::WINDOW_RST;
      rpm_floor   = ttc_pkg::FLOOR_RST;
      trend_limit = ttc_pkg::LIMIT_RST;
      pulse_total = '0;
      elapsed     = '0;
      last_speed  = '0;
      foreach (history[k]) history[k] = '0;
      mismatches  = 0;
    endfunction

    function void set_config(logic [CFG_W-1:0] win, logic [CFG_W-1:0] flr,
                             logic [CFG_W-1:0] lim);
      window_ms   = win;
      rpm_floor   = flr;
      trend_limit = lim;
    endfunction

    function int pending();
      return readings.size();
    endfunction

    // Signed comparison of the truncated history mean against the new speed.
    function ttc_pkg::trend_t grade(logic [RPM_W-1:0] speed);
      longint sum;
      longint diff;
      if (speed <= rpm_floor) return ttc_pkg::TREND_ZERO;
      sum = 0;
      foreach (history[k]) sum += longint'(history[k]);
      diff = sum / HISTORY_DEPTH - longint'(speed);
      if (diff <= -longint'(trend_limit)) return ttc_pkg::TREND_RISING;
      if (diff >= longint'(trend_limit)) return ttc_pkg::TREND_FALLING;
      return ttc_pkg::TREND_STABLE;
    endfunction

    // Called for every accepted tick; queues a reading when the window closes.
    function void take_tick(logic [PULSE_W-1:0] p);
      logic [RPM_W:0]   psum;
      logic [47:0]      quot;
      logic [RPM_W-1:0] speed;
      reading_t         r;
      psum = {1'b0, pulse_total} + (RPM_W + 1)'(p);
      pulse_total = psum[RPM_W] ? REG_MAX : psum[RPM_W-1:0];
      if (elapsed != REG_MAX) elapsed = elapsed + 1'b1;
      if (elapsed <= window_ms) return;
      for (int k = HISTORY_DEPTH - 1; k > 0; k--) history[k] = history[k-1];
      history[0] = last_speed;
      quot = (48'(pulse_total) * 48'd60000) / 48'(elapsed);
      speed = (quot > 48'hFFFF) ? REG_MAX : quot[RPM_W-1:0];
      last_speed = speed;
      r.speed = speed;
      r.trend = grade(speed);
      pulse_total = '0;
      elapsed = '0;
      readings.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_reading(logic [OUT_TDATA_W-1:0] d);
      reading_t want;
      if (readings.size() == 0) begin
        report($sformatf("result beat with none predicted: rpm %0d trend %0d",
                         d[RPM_W-1:0], d[RPM_W+TREND_W-1:RPM_W]));
        return;
      end
      want = readings.pop_front();
      if (d[RPM_W-1:0] !== want.speed)
        report($sformatf("speed_rpm got %0d, predicted %0d", d[RPM_W-1:0], want.speed));
      if (d[RPM_W+TREND_W-1:RPM_W] !== want.trend)
        report($sformatf("trend got %0d, predicted %0d (rpm %0d)",
                         d[RPM_W+TREND_W-1:RPM_W], want.trend, want.speed));
    endtask
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [3:0] pulses, rest zero
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [15:0] speed_rpm, [17:16] trend
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = ttc_pkg::CFG_WINDOW_MS;
  logic [CFG_W-1:0]       cfg_wdata  = '0;

  // While set, neither side holds off, giving one long back-to-back stretch.
  bit        quiet = 1'b0;
  int        stall_cycles = 0;
  rpm_ledger ledger;

  tachometer_trend_classifier u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver stalls at random, except during the quiet stretch.
  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // Result monitor and watchdog. Both sample the values present before the
  // edge, so the checks do not depend on the order of processes in a step.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) ledger.check_reading(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tachometer_trend_classifier regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Sends one tick beat. An optional random gap comes first; valid is only
  // lowered on that path, so it never falls and rises within one step. The
  // tracker is updated here, at the edge where the beat is accepted.
  task send_tick(input logic [PULSE_W-1:0] p);
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(p);
    do @(posedge clk); while (!in_tready);
    ledger.take_tick(p);
  endtask

  // Writes all three registers on consecutive edges; only called when idle.
  task load_regs(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] flr,
                 input logic [CFG_W-1:0] lim);
    cfg_we    <= 1'b1;
    cfg_addr  <= ttc_pkg::CFG_WINDOW_MS;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_addr  <= ttc_pkg::CFG_RPM_FLOOR;
    cfg_wdata <= flr;
    @(posedge clk);
    cfg_addr  <= ttc_pkg::CFG_TREND_LIMIT;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ledger.set_config(win, flr, lim);
  endtask

  // Drops valid, waits for every owed reading, then lets the block run dry.
  task settle();
    in_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pulses per tick. Any average above about one pulse per tick saturates the
  // rpm, so most ticks carry zero or one pulse, with density percent of ones
  // and a little full-range noise. Heavy phases draw the whole range.
  function automatic logic [PULSE_W-1:0] draw_pulses(int density, bit heavy);
    int roll;
    roll = $urandom_range(99);
    if (heavy || roll >= 97) return PULSE_W'($urandom_range(15));
    return (roll < density) ? PULSE_W'(1) : PULSE_W'(0);
  endfunction

  initial begin
    logic [CFG_W-1:0] win;
    logic [CFG_W-1:0] flr;
    logic [CFG_W-1:0] lim;
    int               density;
    bit               heavy;

    ledger = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one reading after 1001 ticks checks the register
    // defaults without any write. The closing part runs with no holding off
    // on either side.
    for (int n = 0; n < 1004; n++) begin
      quiet = (n >= QUIET_FROM);
      send_tick(draw_pulses(30, 1'b0));
    end
    quiet = 1'b0;
    settle();

    // Smallest window with no floor and a zero trend limit: rpm saturation,
    // a zero reading, and differences right at zero.
    load_regs(CFG_W'(1), CFG_W'(0), CFG_W'(0));
    send_tick(4'd15); send_tick(4'd15);
    send_tick(4'd0);  send_tick(4'd0);
    send_tick(4'd1);  send_tick(4'd0);
    send_tick(4'd8);  send_tick(4'd7);
    send_tick(4'd0);  send_tick(4'd1);
    send_tick(4'd2);  send_tick(4'd4);
    settle();

    // Largest floor: even a saturated rpm reports the zero trend.
    load_regs(CFG_W'(2), REG_MAX, REG_MAX);
    send_tick(4'd15); send_tick(4'd15); send_tick(4'd15);
    settle();

    // Floor just under the reading, with the largest trend limit.
    load_regs(CFG_W'(3), CFG_W'(29999), REG_MAX);
    send_tick(4'd1); send_tick(4'd0); send_tick(4'd0); send_tick(4'd1);
    send_tick(4'd0); send_tick(4'd0); send_tick(4'd0); send_tick(4'd0);
    settle();

    // Random settings. The first phase pins the smallest window; most others
    // use very short windows so readings come often, a few use longer ones
    // that may close only in a later phase.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0)
        win = CFG_W'(1);
      else if ($urandom_range(3) == 0)
        win = CFG_W'($urandom_range(12, 6));
      else
        win = CFG_W'($urandom_range(4, 1));
      case ($urandom_range(3))
        0:       flr = '0;
        1:       flr = REG_MAX;
        2:       flr = CFG_W'($urandom_range(40000));
        default: flr = CFG_W'($urandom_range(65535));
      endcase
      case ($urandom_range(3))
        0:       lim = '0;
        1:       lim = REG_MAX;
        2:       lim = CFG_W'($urandom_range(2000));
        default: lim = CFG_W'($urandom_range(65535));
      endcase
      load_regs(win, flr, lim);
      density = $urandom_range(100);
      heavy   = ($urandom_range(4) == 0);
      for (int n = 0; n < PHASE_TICKS; n++) send_tick(draw_pulses(density, heavy));
      settle();
    end

    if (ledger.pending() != 0)
      ledger.report($sformatf("%0d predicted readings never arrived", ledger.pending()));

    if (ledger.mismatches == 0) begin
      $display("tachometer_trend_classifier regression: pass");
    end else begin
      $display("tachometer_trend_classifier regression: fail");
    end
    $finish;
  end

endmodule
